// ===== rtl/dcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_pkg: shared constants and functions of the distinct-count sketch
// Port widths, parameter defaults and the elaboration-time root constants
// that the estimate pipeline uses.
// ----------------------------------------------------------------------------
package dcs_pkg;

	localparam int PARTITION_BITS_DEF = 8;
	localparam int HASH_WIDTH_DEF     = 64;

	localparam int HASH_W     = 64;
	localparam int RANK_SUM_W = 14;
	localparam int EST_W      = 64;

	// Depth of the queue between the classifier and the bucket update.
	localparam int QUEUE_DEPTH = 4;

	// Q1.30 fixed point for the fractional power of two.
	localparam int Q30_W = 31;
	localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(1) << 30;
	// 2^(f/N) in Q2.16 after rounding, up to and including 2.0.
	localparam int FRAC_W = 18;

	// 1/0.77351 in Q1.32, rounded to nearest.
	localparam logic [63:0] INV_PHI_FULL =
		(64'd100000 * 64'd4294967296 + 64'd38675) / 64'd77351;
	localparam int INV_PHI_W = 33;
	localparam logic [INV_PHI_W-1:0] INV_PHI_Q32 = INV_PHI_FULL[INV_PHI_W-1:0];

	// The estimate is taken from a Q48 product.
	localparam int PROD_FRAC = 48;

	// Integer square root, evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > x) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Approximation of 2^(2^-k) in Q1.30, by repeated square roots.
	function automatic logic [Q30_W-1:0] root_q30(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[Q30_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dcs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module dcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_front: input classifier and queue
// Splits each hash into a bucket index and a rank and queues the pair for
// the bucket update.
// ----------------------------------------------------------------------------
module dcs_front
	import dcs_pkg::*;
#(
	parameter int PARTITION_BITS = PARTITION_BITS_DEF,
	parameter int HASH_WIDTH     = HASH_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output      logic                      in_ready,
	input  wire logic [HASH_W-1:0]         hash,
	input  wire logic                      hold,
	input  wire logic                      pop,
	output      logic                      q_valid,
	output      logic [PARTITION_BITS-1:0] q_idx,
	output      logic [$clog2(HASH_WIDTH-PARTITION_BITS+1)-1:0] q_rank
);

	localparam int XW     = HASH_WIDTH - PARTITION_BITS;
	localparam int RKW    = $clog2(XW + 1);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	logic [XW-1:0]             x;
	logic [RKW-1:0]            rank;
	logic                      push;
	logic [PARTITION_BITS-1:0] idx_q  [0:QUEUE_DEPTH-1];
	logic [RKW-1:0]            rank_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [CNT_W-1:0]          cnt_q;

	// The rank is the position of the lowest set bit above the bucket index,
	// or the full width when all those bits are zero.
	always_comb begin
		x    = hash[HASH_WIDTH-1:PARTITION_BITS];
		rank = RKW'(XW);
		for (int i = XW - 1; i >= 0; i--) begin
			if (x[i]) begin
				rank = RKW'(i);
			end
		end
	end

	assign in_ready = !hold && (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_idx    = idx_q[rd_ptr_q];
	assign q_rank   = rank_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			idx_q[wr_ptr_q]  <= hash[PARTITION_BITS-1:0];
			rank_q[wr_ptr_q] <= rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dcs_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_update: bucket read-modify-write and running rank sum
// Reads the bucket bitmap, sets the rank bit, writes it back and adds the
// change in trailing ones to the running sum. Clears all buckets after reset.
// ----------------------------------------------------------------------------
module dcs_update
	import dcs_pkg::*;
#(
	parameter int PARTITION_BITS = PARTITION_BITS_DEF,
	parameter int HASH_WIDTH     = HASH_WIDTH_DEF,
	parameter int SUM_W          = 14
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      q_valid,
	input  wire logic [PARTITION_BITS-1:0] q_idx,
	input  wire logic [$clog2(HASH_WIDTH-PARTITION_BITS+1)-1:0] q_rank,
	output      logic                      pop,
	output      logic                      clearing,
	output      logic [SUM_W-1:0]          sum,
	output      logic                      sum_valid
);

	localparam int NB  = 2 ** PARTITION_BITS;
	localparam int BW  = HASH_WIDTH - PARTITION_BITS + 1;
	localparam int RKW = $clog2(BW);
	localparam int TW  = $clog2(BW + 1);

	logic                      clearing_q;
	logic [PARTITION_BITS-1:0] clr_idx_q;
	logic                      vld_s1;
	logic [PARTITION_BITS-1:0] idx_s1;
	logic [RKW-1:0]            rank_s1;
	logic                      byp_vld_q;
	logic [PARTITION_BITS-1:0] byp_idx_q;
	logic [BW-1:0]             byp_bits_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      vld_s2;
	logic [BW-1:0]             rdata;
	logic [BW-1:0]             old_bits;
	logic [BW-1:0]             upd_bits;
	logic [TW-1:0]             t0;
	logic [TW-1:0]             t1;
	logic                      commit;
	logic                      we;
	logic [PARTITION_BITS-1:0] waddr;
	logic [BW-1:0]             wdata;

	assign pop      = adv && q_valid && !clearing_q;
	assign commit   = adv && vld_s1;
	assign clearing = clearing_q;

	// The bucket written in the previous cycle is not yet visible to a read
	// issued in that same cycle, so it is taken from the bypass register.
	always_comb begin
		if (byp_vld_q && (byp_idx_q == idx_s1)) begin
			old_bits = byp_bits_q;
		end else begin
			old_bits = rdata;
		end
		upd_bits = old_bits | (BW'(1) << rank_s1);
		t0 = TW'(BW);
		t1 = TW'(BW);
		for (int i = BW - 1; i >= 0; i--) begin
			if (!old_bits[i]) begin
				t0 = TW'(i);
			end
			if (!upd_bits[i]) begin
				t1 = TW'(i);
			end
		end
	end

	always_comb begin
		we    = clearing_q || commit;
		waddr = clearing_q ? clr_idx_q : idx_s1;
		wdata = clearing_q ? '0 : upd_bits;
	end

	dcs_ram #(
		.WIDTH(BW),
		.DEPTH(NB)
	) u_bucket_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (pop),
		.raddr(q_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_s1  <= q_idx;
			rank_s1 <= q_rank;
		end
		if (commit) begin
			byp_idx_q  <= idx_s1;
			byp_bits_q <= upd_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			byp_vld_q  <= 1'b0;
			sum_q      <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + PARTITION_BITS'(1);
				if (&clr_idx_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv) begin
				vld_s1 <= pop;
				vld_s2 <= vld_s1;
			end
			if (commit) begin
				byp_vld_q <= 1'b1;
				sum_q     <= sum_q + SUM_W'(t1 - t0);
			end
		end
	end

	assign sum       = sum_q;
	assign sum_valid = vld_s2;

endmodule
`default_nettype wire

// ===== rtl/dcs_estimate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_estimate: fixed-point estimate pipeline
// One stage per fraction bit builds 2^(f/N), then a multiply by N/0.77351
// and a final rounding shift by the integer part with saturation.
// ----------------------------------------------------------------------------
module dcs_estimate
	import dcs_pkg::*;
#(
	parameter int PARTITION_BITS = PARTITION_BITS_DEF,
	parameter int SUM_W          = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  sum_valid,
	input  wire logic [SUM_W-1:0]      sum,
	output      logic                  out_valid,
	output      logic [RANK_SUM_W-1:0] rank_sum,
	output      logic [EST_W-1:0]      estimate
);

	localparam int P      = PARTITION_BITS;
	localparam int QW     = 6;
	localparam int MULT_W = INV_PHI_W + FRAC_W;

	logic [Q30_W-1:0]      root_c  [0:P-1];
	logic [Q30_W-1:0]      v_src   [0:P-1];
	logic [P-1:0]          f_src   [0:P-1];
	logic [QW-1:0]         q_src   [0:P-1];
	logic [RANK_SUM_W-1:0] rs_src  [0:P-1];
	logic                  vld_src [0:P-1];
	logic [2*Q30_W-1:0]    prod    [0:P-1];
	logic [Q30_W-1:0]      v_nx    [0:P-1];

	logic [Q30_W-1:0]      v_sf   [0:P-1];
	logic [P-1:0]          f_sf   [0:P-1];
	logic [QW-1:0]         q_sf   [0:P-1];
	logic [RANK_SUM_W-1:0] rs_sf  [0:P-1];
	logic                  vld_sf [0:P-1];

	logic [Q30_W:0]        v_round;
	logic [FRAC_W-1:0]     frac_q16;
	logic [MULT_W-1:0]     prod_sm;
	logic [QW-1:0]         q_sm;
	logic [RANK_SUM_W-1:0] rs_sm;
	logic                  vld_sm;

	logic [EST_W-1:0]      m_full;
	logic [EST_W-1:0]      est_nx;
	logic [3:0]            up_sh;
	logic [QW-1:0]         dn_sh;

	logic                  vld_so;
	logic [RANK_SUM_W-1:0] rs_so;
	logic [EST_W-1:0]      est_so;

	for (genvar k = 0; k < P; k++) begin : g_root
		localparam logic [Q30_W-1:0] CK = root_q30(k + 1);
		assign root_c[k] = CK;
	end

	// Stage k multiplies by 2^(2^-(k+1)) when the matching fraction bit is set.
	always_comb begin
		v_src[0]   = ONE_Q30;
		f_src[0]   = sum[P-1:0];
		q_src[0]   = QW'(sum >> P);
		rs_src[0]  = RANK_SUM_W'(sum);
		vld_src[0] = sum_valid;
		for (int k = 1; k < P; k++) begin
			v_src[k]   = v_sf[k-1];
			f_src[k]   = f_sf[k-1];
			q_src[k]   = q_sf[k-1];
			rs_src[k]  = rs_sf[k-1];
			vld_src[k] = vld_sf[k-1];
		end
		for (int k = 0; k < P; k++) begin
			prod[k] = (2*Q30_W)'(v_src[k]) * (2*Q30_W)'(root_c[k]);
			if (f_src[k][P-1-k]) begin
				v_nx[k] = prod[k][Q30_W+29:30];
			end else begin
				v_nx[k] = v_src[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < P; k++) begin
				v_sf[k]  <= v_nx[k];
				f_sf[k]  <= f_src[k];
				q_sf[k]  <= q_src[k];
				rs_sf[k] <= rs_src[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < P; k++) begin
				vld_sf[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < P; k++) begin
				vld_sf[k] <= vld_src[k];
			end
		end
	end

	// Round Q1.30 to Q2.16 and scale by 1/0.77351.
	assign v_round  = {1'b0, v_sf[P-1]} + (Q30_W+1)'(1 << 13);
	assign frac_q16 = v_round[Q30_W:14];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sm <= MULT_W'(INV_PHI_Q32) * MULT_W'(frac_q16);
			q_sm    <= q_sf[P-1];
			rs_sm   <= rs_sf[P-1];
		end
	end

	// The product times N is a Q48 value; shift it by the integer part.
	always_comb begin
		m_full = EST_W'(prod_sm) << P;
		up_sh  = '0;
		dn_sh  = '0;
		if (q_sm >= QW'(PROD_FRAC)) begin
			up_sh = 4'(q_sm - QW'(PROD_FRAC));
			if (m_full > ({EST_W{1'b1}} >> up_sh)) begin
				est_nx = {EST_W{1'b1}};
			end else begin
				est_nx = m_full << up_sh;
			end
		end else begin
			dn_sh  = QW'(PROD_FRAC) - q_sm;
			est_nx = (m_full + (EST_W'(1) << (dn_sh - QW'(1)))) >> dn_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			est_so <= est_nx;
			rs_so  <= rs_sm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
			vld_so <= 1'b0;
		end else if (en) begin
			vld_sm <= vld_sf[P-1];
			vld_so <= vld_sm;
		end
	end

	assign out_valid = vld_so;
	assign rank_sum  = rs_so;
	assign estimate  = est_so;

endmodule
`default_nettype wire

// ===== rtl/distinct_count_sketch_core.sv =====
`default_nettype none
// Path: a hash passes the queue, the bucket read stage, the rank sum register,
// the fraction-power stages, the multiply register and the output register.
// Throughput: one hash per cycle unless the output stalls or the RAM is being
// cleared; the bucket RAM is read and written once per item, with a bypass for
// back-to-back hits on the same bucket. Reset: after arst_n is released the
// bucket RAM is cleared one bucket per cycle, while in_ready stays low.
// ----------------------------------------------------------------------------
// distinct_count_sketch_core: PCSA distinct-count estimator
// Classifier and queue in front, bucket update and estimate pipeline behind.
// ----------------------------------------------------------------------------
module distinct_count_sketch_core
	import dcs_pkg::*;
#(
	parameter int PARTITION_BITS = PARTITION_BITS_DEF,
	parameter int HASH_WIDTH     = HASH_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [HASH_W-1:0]     hash,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [RANK_SUM_W-1:0] rank_sum,
	output      logic [EST_W-1:0]      estimate
);

	localparam int BW    = HASH_WIDTH - PARTITION_BITS + 1;
	localparam int RKW   = $clog2(BW);
	localparam int SUM_W = $clog2((2 ** PARTITION_BITS) * BW + 1);

	logic                      adv;
	logic                      hold;
	logic                      pop;
	logic                      q_valid;
	logic [PARTITION_BITS-1:0] q_idx;
	logic [RKW-1:0]            q_rank;
	logic [SUM_W-1:0]          sum;
	logic                      sum_valid;

	// The back end moves as one pipeline whenever the output register is free.
	assign adv = !(out_valid && !out_ready);

	dcs_front #(
		.PARTITION_BITS(PARTITION_BITS),
		.HASH_WIDTH    (HASH_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hash    (hash),
		.hold    (hold),
		.pop     (pop),
		.q_valid (q_valid),
		.q_idx   (q_idx),
		.q_rank  (q_rank)
	);

	dcs_update #(
		.PARTITION_BITS(PARTITION_BITS),
		.HASH_WIDTH    (HASH_WIDTH),
		.SUM_W         (SUM_W)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.q_valid  (q_valid),
		.q_idx    (q_idx),
		.q_rank   (q_rank),
		.pop      (pop),
		.clearing (hold),
		.sum      (sum),
		.sum_valid(sum_valid)
	);

	dcs_estimate #(
		.PARTITION_BITS(PARTITION_BITS),
		.SUM_W         (SUM_W)
	) u_estimate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.sum_valid(sum_valid),
		.sum      (sum),
		.out_valid(out_valid),
		.rank_sum (rank_sum),
		.estimate (estimate)
	);

endmodule
`default_nettype wire
